@@ hdl/assert_macros.svh @@
// assertion macros shared by the lfo core rtl
// assumes clk and rst are visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// expression must never be true outside reset
`define MSL_ASSERT_NEVER(lbl, expr, msg) \
  `MSL_ASSERT(lbl, !(expr), msg)

`endif

@@ hdl/msl_pkg.sv @@
// shared types, constants and the sine table for the modulated sine lfo core
// no dependencies
package msl_pkg;

  localparam int SINE_DEPTH = 1024;
  localparam int PHASE_BITS = 32;
  localparam int IDX_W      = $clog2(SINE_DEPTH);
  localparam int STEP_SHIFT = 48 - PHASE_BITS;

  localparam int SET_W      = 16;
  localparam int PSS_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int REG_IDX_W  = 3;
  localparam int OUT_W      = 16;
  localparam int SINE_W     = 16;
  localparam int SM_W       = 20;
  localparam int MUL_W      = 25;
  localparam int PROD_W     = 2 * MUL_W;

  localparam int HZ_MIN       = 655;
  localparam int HZ_SPAN      = 523633;
  localparam int RATE_SM_INIT = 32768;

  localparam logic [SET_W-1:0] BASE_RATE_INIT    = 16'd32768;
  localparam logic [SET_W-1:0] BASE_DEPTH_INIT   = 16'd32768;
  localparam logic [SET_W-1:0] PHASE_OFFSET_INIT = 16'd0;
  localparam logic [SET_W-1:0] RATE_AMOUNT_INIT  = 16'd32768;
  localparam logic [SET_W-1:0] DEPTH_AMOUNT_INIT = 16'd32768;
  localparam logic [PSS_W-1:0] PSS_INIT          = 24'd89478;
  localparam logic [SET_W-1:0] SMOOTH_COEFF_INIT = 16'd655;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_RATE    = 3'd0,
    REG_BASE_DEPTH   = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_RATE_AMOUNT  = 3'd3,
    REG_DEPTH_AMOUNT = 3'd4,
    REG_PSS          = 3'd5,
    REG_SMOOTH_COEFF = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SET_W-1:0] base_rate;
    logic [SET_W-1:0] base_depth;
    logic [SET_W-1:0] phase_offset;
    logic [SET_W-1:0] rate_amount;
    logic [SET_W-1:0] depth_amount;
    logic [PSS_W-1:0] phase_step_scale;
    logic [SET_W-1:0] smooth_coeff;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ENV_RATE,
    MUL_ENV_DEPTH,
    MUL_COEF_RATE,
    MUL_COEF_DEPTH,
    MUL_RATE_SPAN,
    MUL_HZ_SCALE,
    MUL_SINE_DEPTH
  } mul_sel_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_RATE_DIFF,
    ALU_DEPTH_DIFF,
    ALU_RATE_UPD,
    ALU_DEPTH_UPD,
    ALU_HZ,
    ALU_PHASE
  } alu_op_t;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  alu;
    logic     rom_rd;
    logic     in_fire;
    logic     emit;
  } ctrl_t;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  // quarter-wave taylor series in q30, folded to a full cycle
  function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned k);
    longint unsigned t;
    longint unsigned f;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned v;
    logic [1:0] quad;
    t = (64'(k) << 32) / SINE_DEPTH;
    quad = t[31:30];
    f = t & (Q30_ONE - 64'd1);
    if (quad[0]) f = Q30_ONE - f;
    x  = (f * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    p  = Q30_ONE;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd110;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd72;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd42;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd20;
    p  = Q30_ONE - ((x2 * p) >> 30) / 64'd6;
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (v > 64'd32767) v = 64'd32767;
    return quad[1] ? -SINE_W'(v) : SINE_W'(v);
  endfunction

  function automatic sine_rom_t sine_table();
    sine_rom_t tbl;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      tbl[k] = sine_entry(k);
    end
    return tbl;
  endfunction

  localparam sine_rom_t SINE_ROM = sine_table();

endpackage

@@ hdl/msl_regs.sv @@
// configuration register file of the lfo core
// depends on msl_pkg
module msl_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [msl_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [msl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output msl_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_rate        <= msl_pkg::BASE_RATE_INIT;
      cfg.base_depth       <= msl_pkg::BASE_DEPTH_INIT;
      cfg.phase_offset     <= msl_pkg::PHASE_OFFSET_INIT;
      cfg.rate_amount      <= msl_pkg::RATE_AMOUNT_INIT;
      cfg.depth_amount     <= msl_pkg::DEPTH_AMOUNT_INIT;
      cfg.phase_step_scale <= msl_pkg::PSS_INIT;
      cfg.smooth_coeff     <= msl_pkg::SMOOTH_COEFF_INIT;
    end else if (cfg_wr_en) begin
      unique case (msl_pkg::reg_idx_t'(cfg_index))
        msl_pkg::REG_BASE_RATE:    cfg.base_rate    <= cfg_data[msl_pkg::SET_W-1:0];
        msl_pkg::REG_BASE_DEPTH:   cfg.base_depth   <= cfg_data[msl_pkg::SET_W-1:0];
        msl_pkg::REG_PHASE_OFFSET: cfg.phase_offset <= cfg_data[msl_pkg::SET_W-1:0];
        msl_pkg::REG_RATE_AMOUNT:  cfg.rate_amount  <= cfg_data[msl_pkg::SET_W-1:0];
        msl_pkg::REG_DEPTH_AMOUNT: cfg.depth_amount <= cfg_data[msl_pkg::SET_W-1:0];
        msl_pkg::REG_PSS:          cfg.phase_step_scale <= cfg_data[msl_pkg::PSS_W-1:0];
        msl_pkg::REG_SMOOTH_COEFF: cfg.smooth_coeff <= cfg_data[msl_pkg::SET_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/msl_useq.sv @@
// microcode sequencer: step counter, control store and handshake decisions
// depends on msl_pkg and assert_macros.svh
`include "assert_macros.svh"
module msl_useq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_busy,
  output msl_pkg::ctrl_t ctrl
);

  localparam int STEP_COUNT = 12;
  localparam int STEP_W     = $clog2(STEP_COUNT);

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_JUMP,
    SEQ_WAIT_IN,
    SEQ_EMIT
  } seq_t;

  typedef struct packed {
    seq_t               seq;
    logic [STEP_W-1:0]  jump;
    msl_pkg::mul_sel_t  mul;
    msl_pkg::alu_op_t   alu;
    logic               rom_rd;
  } ucode_t;

  localparam logic [STEP_W-1:0] STEP_WAIT      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_ENV_RATE  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RATE_DIFF = 4'd2;
  localparam logic [STEP_W-1:0] STEP_DEPTH_DIF = 4'd3;
  localparam logic [STEP_W-1:0] STEP_RATE_UPD  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DEPTH_UPD = 4'd5;
  localparam logic [STEP_W-1:0] STEP_HZ        = 4'd6;
  localparam logic [STEP_W-1:0] STEP_HZ_MUL    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_PHASE     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_ROM       = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SINE_MUL  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 4'd11;

  // control store
  function automatic ucode_t ucode(logic [STEP_W-1:0] s);
    ucode_t u;
    u = '{seq: SEQ_NEXT, jump: STEP_WAIT, mul: msl_pkg::MUL_NONE,
          alu: msl_pkg::ALU_NOP, rom_rd: 1'b0};
    unique case (s)
      STEP_WAIT:      u.seq = SEQ_WAIT_IN;
      STEP_ENV_RATE:  u.mul = msl_pkg::MUL_ENV_RATE;
      STEP_RATE_DIFF: begin
        u.alu = msl_pkg::ALU_RATE_DIFF;
        u.mul = msl_pkg::MUL_ENV_DEPTH;
      end
      STEP_DEPTH_DIF: begin
        u.alu = msl_pkg::ALU_DEPTH_DIFF;
        u.mul = msl_pkg::MUL_COEF_RATE;
      end
      STEP_RATE_UPD: begin
        u.alu = msl_pkg::ALU_RATE_UPD;
        u.mul = msl_pkg::MUL_COEF_DEPTH;
      end
      STEP_DEPTH_UPD: begin
        u.alu = msl_pkg::ALU_DEPTH_UPD;
        u.mul = msl_pkg::MUL_RATE_SPAN;
      end
      STEP_HZ:        u.alu = msl_pkg::ALU_HZ;
      STEP_HZ_MUL:    u.mul = msl_pkg::MUL_HZ_SCALE;
      STEP_PHASE:     u.alu = msl_pkg::ALU_PHASE;
      STEP_ROM:       u.rom_rd = 1'b1;
      STEP_SINE_MUL:  u.mul = msl_pkg::MUL_SINE_DEPTH;
      STEP_EMIT:      u.seq = SEQ_EMIT;
      default:        u.seq = SEQ_JUMP;
    endcase
    return u;
  endfunction

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  logic              in_fire;
  logic              emit;

  assign uw = ucode(step);

  always_comb begin
    step_next = step;
    in_fire   = 1'b0;
    emit      = 1'b0;
    unique case (uw.seq)
      SEQ_NEXT: step_next = step + STEP_W'(1);
      SEQ_JUMP: step_next = uw.jump;
      SEQ_WAIT_IN: begin
        if (in_valid) begin
          in_fire   = 1'b1;
          step_next = step + STEP_W'(1);
        end
      end
      SEQ_EMIT: begin
        if (!out_busy) begin
          emit      = 1'b1;
          step_next = uw.jump;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  assign in_stall     = (uw.seq != SEQ_WAIT_IN);
  assign ctrl.mul     = uw.mul;
  assign ctrl.alu     = uw.alu;
  assign ctrl.rom_rd  = uw.rom_rd;
  assign ctrl.in_fire = in_fire;
  assign ctrl.emit    = emit;

  `MSL_ASSERT_NEVER(a_step_range, step > STEP_EMIT, "step counter outside the program")
  `MSL_ASSERT(a_fire_to_emit, in_fire |-> ##(STEP_EMIT) (step == STEP_EMIT), "item missed emit step")
  `MSL_ASSERT(a_emit_hold, (uw.seq == SEQ_EMIT && out_busy) |=> $stable(step), "emit step left early")

endmodule

@@ hdl/msl_dpath.sv @@
// datapath: shared multiplier, alu, smoothing state, phase accumulator, sine rom, output register
// depends on msl_pkg
module msl_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  msl_pkg::ctrl_t                      ctrl,
  input  msl_pkg::cfg_t                       cfg,
  input  logic [msl_pkg::SET_W-1:0]           env_level,
  input  logic                                block_last_in,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [msl_pkg::OUT_W-1:0]    lfo_value,
  output logic                                block_last_out,
  output logic                                out_busy
);

  localparam int MUL_W  = msl_pkg::MUL_W;
  localparam int PROD_W = msl_pkg::PROD_W;
  localparam int SM_W   = msl_pkg::SM_W;
  localparam int PB     = msl_pkg::PHASE_BITS;
  localparam int DIFF_W = SM_W + 1;
  localparam int SUM_W  = SM_W + 2;
  localparam int HZS_W  = 24;
  localparam int HZ_W   = HZS_W - 1;
  localparam int AMT_W  = msl_pkg::SET_W + 2;
  localparam int OFFS_W = PB + 14;

  localparam logic signed [MUL_W-1:0]  SPAN_K  = MUL_W'(msl_pkg::HZ_SPAN);
  localparam logic signed [PROD_W-1:0] HALF16  = PROD_W'(64'd1 << 15);
  localparam logic signed [PROD_W-1:0] HALF18  = PROD_W'(64'd1 << 17);
  localparam logic [PROD_W-1:0]        STEP_HALF =
    PROD_W'((64'd1 << msl_pkg::STEP_SHIFT) >> 1);
  localparam logic signed [SUM_W-1:0]  SM_HI   = SUM_W'((1 << (SM_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SM_LO   = -SM_HI - SUM_W'(1);
  localparam logic signed [PROD_W-1:0] Y_HI    = PROD_W'((1 << (msl_pkg::OUT_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] Y_LO    = -Y_HI - PROD_W'(1);
  localparam logic signed [HZS_W-1:0]  HZ_MIN_S = HZS_W'(msl_pkg::HZ_MIN);

  function automatic logic signed [SM_W-1:0] sat_sm(logic signed [SUM_W-1:0] v);
    if (v > SM_HI) return SM_HI[SM_W-1:0];
    if (v < SM_LO) return SM_LO[SM_W-1:0];
    return SM_W'(v);
  endfunction

  logic [msl_pkg::SET_W-1:0]          env;
  logic                               last_in;
  logic signed [PROD_W-1:0]           p;
  logic signed [DIFF_W-1:0]           diff_r;
  logic signed [DIFF_W-1:0]           diff_d;
  logic signed [SM_W-1:0]             rate_sm;
  logic signed [SM_W-1:0]             depth_sm;
  logic [HZ_W-1:0]                    hz;
  logic [PB-1:0]                      phase_acc;
  logic signed [msl_pkg::SINE_W-1:0]  sine;

  logic signed [AMT_W-1:0]  m_rate;
  logic signed [AMT_W-1:0]  m_depth;
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] p_r16;
  logic signed [PROD_W-1:0] p_r18;
  logic signed [DIFF_W-1:0] base_r;
  logic signed [DIFF_W-1:0] base_d;
  logic signed [DIFF_W-1:0] tgt_r;
  logic signed [DIFF_W-1:0] tgt_r_c;
  logic signed [DIFF_W-1:0] tgt_d;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [HZS_W-1:0]  hz_s;
  logic [HZ_W-1:0]          hz_next;
  logic [PB-1:0]            step_v;
  logic [PB-1:0]            offs;
  logic [PB-1:0]            ph;
  logic [msl_pkg::IDX_W-1:0] rom_idx;
  logic signed [msl_pkg::OUT_W-1:0] y_sat;

  // amount a maps to 4a - 2.0 in q16
  assign m_rate  = {~cfg.rate_amount[msl_pkg::SET_W-1],
                    cfg.rate_amount[msl_pkg::SET_W-2:0], 2'b00};
  assign m_depth = {~cfg.depth_amount[msl_pkg::SET_W-1],
                    cfg.depth_amount[msl_pkg::SET_W-2:0], 2'b00};

  always_comb begin
    unique case (ctrl.mul)
      msl_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      msl_pkg::MUL_ENV_RATE: begin
        mul_a = MUL_W'(env);
        mul_b = MUL_W'(m_rate);
      end
      msl_pkg::MUL_ENV_DEPTH: begin
        mul_a = MUL_W'(env);
        mul_b = MUL_W'(m_depth);
      end
      msl_pkg::MUL_COEF_RATE: begin
        mul_a = MUL_W'(cfg.smooth_coeff);
        mul_b = MUL_W'(diff_r);
      end
      msl_pkg::MUL_COEF_DEPTH: begin
        mul_a = MUL_W'(cfg.smooth_coeff);
        mul_b = MUL_W'(diff_d);
      end
      msl_pkg::MUL_RATE_SPAN: begin
        mul_a = MUL_W'(rate_sm);
        mul_b = SPAN_K;
      end
      msl_pkg::MUL_HZ_SCALE: begin
        mul_a = MUL_W'(hz);
        mul_b = MUL_W'(cfg.phase_step_scale);
      end
      msl_pkg::MUL_SINE_DEPTH: begin
        mul_a = MUL_W'(sine);
        mul_b = MUL_W'(depth_sm);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod  = mul_a * mul_b;
  assign p_r16 = (p + HALF16) >>> 16;
  assign p_r18 = (p + HALF18) >>> 18;

  // targets and differences
  assign base_r  = DIFF_W'(cfg.base_rate);
  assign base_d  = DIFF_W'(cfg.base_depth);
  assign tgt_r   = base_r + DIFF_W'(p_r16);
  assign tgt_r_c = tgt_r[DIFF_W-1] ? '0 : tgt_r;
  assign tgt_d   = base_d + DIFF_W'(p_r16);

  // one-pole updates
  assign sum_r = SUM_W'(rate_sm) + SUM_W'(p_r16);
  assign sum_d = SUM_W'(depth_sm) + SUM_W'(p_r16);

  // rate to hertz in q16
  assign hz_s    = HZS_W'(p_r16) + HZ_MIN_S;
  assign hz_next = hz_s[HZS_W-1] ? '0 : HZ_W'(hz_s);

  // phase step, offset and table index
  assign step_v  = PB'((p + STEP_HALF) >> msl_pkg::STEP_SHIFT);
  assign offs    = PB'((OFFS_W'(cfg.phase_offset) << (PB - 2)) >> 16);
  assign ph      = phase_acc + offs;
  assign rom_idx = ph[PB-1 -: msl_pkg::IDX_W];

  always_comb begin
    if (p_r18 > Y_HI) begin
      y_sat = Y_HI[msl_pkg::OUT_W-1:0];
    end else if (p_r18 < Y_LO) begin
      y_sat = Y_LO[msl_pkg::OUT_W-1:0];
    end else begin
      y_sat = msl_pkg::OUT_W'(p_r18);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.in_fire) begin
      env     <= env_level;
      last_in <= block_last_in;
    end
    if (ctrl.mul != msl_pkg::MUL_NONE) begin
      p <= prod;
    end
    if (ctrl.alu == msl_pkg::ALU_RATE_DIFF) begin
      diff_r <= tgt_r_c - DIFF_W'(rate_sm);
    end
    if (ctrl.alu == msl_pkg::ALU_DEPTH_DIFF) begin
      diff_d <= tgt_d - DIFF_W'(depth_sm);
    end
    if (ctrl.alu == msl_pkg::ALU_HZ) begin
      hz <= hz_next;
    end
    if (ctrl.rom_rd) begin
      sine <= msl_pkg::SINE_ROM[rom_idx];
    end
    if (ctrl.emit) begin
      lfo_value      <= y_sat;
      block_last_out <= last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_sm   <= SM_W'(msl_pkg::RATE_SM_INIT);
      depth_sm  <= '0;
      phase_acc <= '0;
    end else begin
      if (ctrl.alu == msl_pkg::ALU_RATE_UPD) begin
        rate_sm <= sat_sm(sum_r);
      end
      if (ctrl.alu == msl_pkg::ALU_DEPTH_UPD) begin
        depth_sm <= sat_sm(sum_d);
      end
      if (ctrl.alu == msl_pkg::ALU_PHASE) begin
        phase_acc <= phase_acc + step_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign out_busy = out_valid & out_stall;

endmodule

@@ hdl/modulated_sine_lfo_core.sv @@
// top level of the modulated sine lfo core
// depends on msl_pkg, msl_regs, msl_useq and msl_dpath
//
//   channel   handshake              payload
//   in        in_valid / in_stall    env_level, block_last_in
//   out       out_valid / out_stall  lfo_value, block_last_out
//   cfg       cfg_wr_en              cfg_index, cfg_data
//
// a result is registered on the emit step of the microprogram, and the next item
// is accepted only after the previous one has been emitted
// the microprogram runs every item through the single shared 25x25 multiplier
// rst is synchronous: phase 0, smoothed rate 0.5, smoothed depth 0, registers to defaults
// the sine table is a constant rom, so there is no fill pass after reset
// out_stall holds the sequencer on its emit step only while an earlier result waits
module modulated_sine_lfo_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [msl_pkg::SET_W-1:0]           env_level,
  input  logic                                block_last_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [msl_pkg::OUT_W-1:0]    lfo_value,
  output logic                                block_last_out,
  input  logic                                cfg_wr_en,
  input  logic [msl_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [msl_pkg::CFG_DATA_W-1:0]      cfg_data
);

  msl_pkg::cfg_t  cfg;
  msl_pkg::ctrl_t ctrl;
  logic           out_busy;

  msl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msl_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_busy (out_busy),
    .ctrl     (ctrl)
  );

  msl_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .cfg            (cfg),
    .env_level      (env_level),
    .block_last_in  (block_last_in),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .lfo_value      (lfo_value),
    .block_last_out (block_last_out),
    .out_busy       (out_busy)
  );

endmodule
